### hdl/dwe_pkg.sv
package dwe_pkg;

   localparam int DICT_BYTES_DEF = 2048;
   localparam int DICT_WORDS_DEF = 256;
   localparam int WORD_MAX_DEF   = 64;

   localparam logic [7:0] CODE_STREAM_END = 8'h00;
   localparam logic [7:0] CODE_MARK       = 8'hFF;
   localparam logic [7:0] CODE_HIGH       = 8'h80;

   typedef enum logic [2:0] {
      KIND_CHAR       = 3'd0,
      KIND_NAME_END   = 3'd1,
      KIND_STREAM_END = 3'd2,
      KIND_BAD_INDEX  = 3'd3,
      KIND_OVERFLOW   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TABLE,
      ST_CHAR
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic load_start;
      logic emit_bad;
      logic emit_char;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic start_expand;
      logic start_bad;
      logic char_last;
   } status_type;

endpackage

### hdl/dwe_ctrl.sv
module dwe_ctrl
   import dwe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.out_free && status.start_expand) begin
               state_in = ST_TABLE;
            end
         end
         ST_TABLE: begin
            if (!status.start_bad) begin
               state_in = ST_CHAR;
            end else if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_CHAR: begin
            if (status.out_free && status.char_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take_byte = status.out_free;
         end
         ST_TABLE: begin
            cmd.load_start = !status.start_bad;
            cmd.emit_bad   = status.start_bad && status.out_free;
         end
         ST_CHAR: begin
            cmd.emit_char = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### hdl/dwe_datapath.sv
module dwe_datapath
   import dwe_pkg::*;
#(
   parameter int DICT_BYTES = DICT_BYTES_DEF,
   parameter int DICT_WORDS = DICT_WORDS_DEF,
   parameter int WORD_MAX   = WORD_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_code_byte,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic [2:0] rsp_out_kind,
   output logic [6:0] rsp_out_char,
   output logic       rsp_run_last,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int ADDR_W = $clog2(DICT_BYTES);
   localparam int FILL_W = $clog2(DICT_BYTES + 1);
   localparam int WIDX_W = $clog2(DICT_WORDS);
   localparam int WC_W   = $clog2(DICT_WORDS + 1);
   localparam int K_W    = $clog2(WORD_MAX);

   logic [7:0]        dict_mem [DICT_BYTES];
   logic [ADDR_W-1:0] table_mem [DICT_WORDS];

   logic              name_phase_ff, name_phase_in;
   logic [WC_W-1:0]   word_count_ff, word_count_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] cur_ff, cur_in;
   logic [FILL_W-1:0] addr_ff, addr_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [7:0]        dict_q_ff;
   logic [ADDR_W-1:0] tbl_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff, kind_in;
   logic [6:0]        char_ff, char_in;
   logic              last_ff, last_in;

   logic              accept;
   logic              is_zero, is_mark, is_close;
   logic              store_full, words_full;
   logic [7:0]        idx;
   logic              idx_bad;
   logic              out_load;
   logic              dict_wr, tbl_wr, tbl_rd, dict_rd;
   logic [ADDR_W-1:0] dict_rd_addr;
   logic [FILL_W-1:0] addr_nx;

   assign accept     = cmd.take_byte && req_valid;
   assign is_zero    = req_code_byte == CODE_STREAM_END;
   assign is_mark    = req_code_byte == CODE_MARK;
   assign is_close   = req_code_byte > CODE_HIGH;
   assign store_full = fill_ff == FILL_W'(DICT_BYTES);
   assign words_full = word_count_ff == WC_W'(DICT_WORDS);
   assign idx        = req_code_byte - 8'd1;
   assign idx_bad    = {1'b0, idx} >= 9'(word_count_ff);
   assign addr_nx    = addr_ff + FILL_W'(1);

   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.start_expand = name_phase_ff && !is_zero && !is_mark && !idx_bad;
   assign status.start_bad    = FILL_W'(tbl_q_ff) >= fill_ff;
   assign status.char_last    = dict_q_ff[7] || (k_ff == K_W'(WORD_MAX - 1))
                                || (addr_nx >= fill_ff);

   always_comb begin
      name_phase_in = name_phase_ff;
      word_count_in = word_count_ff;
      fill_in       = fill_ff;
      cur_in        = cur_ff;
      addr_in       = addr_ff;
      k_in          = k_ff;
      out_load      = 1'b0;
      kind_in       = kind_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      dict_wr       = 1'b0;
      tbl_wr        = 1'b0;
      tbl_rd        = 1'b0;
      dict_rd       = 1'b0;
      dict_rd_addr  = addr_nx[ADDR_W-1:0];

      if (accept) begin
         if (is_zero) begin
            out_load      = 1'b1;
            kind_in       = KIND_STREAM_END;
            char_in       = '0;
            last_in       = 1'b1;
            name_phase_in = 1'b0;
            word_count_in = '0;
            fill_in       = '0;
            cur_in        = '0;
         end else if (!name_phase_ff) begin
            if (is_mark) begin
               name_phase_in = 1'b1;
            end else if (store_full || (is_close && words_full)) begin
               out_load = 1'b1;
               kind_in  = KIND_OVERFLOW;
               char_in  = '0;
               last_in  = 1'b1;
            end else begin
               dict_wr = 1'b1;
               fill_in = fill_ff + FILL_W'(1);
               if (is_close) begin
                  tbl_wr        = 1'b1;
                  word_count_in = word_count_ff + WC_W'(1);
                  cur_in        = fill_ff + FILL_W'(1);
               end
            end
         end else begin
            if (is_mark) begin
               out_load = 1'b1;
               kind_in  = KIND_NAME_END;
               char_in  = '0;
               last_in  = 1'b1;
            end else if (idx_bad) begin
               out_load = 1'b1;
               kind_in  = KIND_BAD_INDEX;
               char_in  = '0;
               last_in  = 1'b1;
            end else begin
               tbl_rd = 1'b1;
            end
         end
      end

      if (cmd.load_start) begin
         addr_in      = FILL_W'(tbl_q_ff);
         k_in         = '0;
         dict_rd      = 1'b1;
         dict_rd_addr = tbl_q_ff;
      end

      if (cmd.emit_bad) begin
         out_load = 1'b1;
         kind_in  = KIND_BAD_INDEX;
         char_in  = '0;
         last_in  = 1'b1;
      end

      if (cmd.emit_char) begin
         out_load = 1'b1;
         kind_in  = KIND_CHAR;
         char_in  = dict_q_ff[6:0];
         last_in  = status.char_last;
         if (!status.char_last) begin
            addr_in = addr_nx;
            k_in    = k_ff + K_W'(1);
            dict_rd = 1'b1;
         end
      end

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         name_phase_ff <= 1'b0;
         word_count_ff <= '0;
         fill_ff       <= '0;
         cur_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         name_phase_ff <= name_phase_in;
         word_count_ff <= word_count_in;
         fill_ff       <= fill_in;
         cur_ff        <= cur_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      k_ff    <= k_in;
      if (out_load) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dict_wr) begin
         dict_mem[fill_ff[ADDR_W-1:0]] <= req_code_byte;
      end
      if (dict_rd) begin
         dict_q_ff <= dict_mem[dict_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         table_mem[word_count_ff[WIDX_W-1:0]] <= cur_ff[ADDR_W-1:0];
      end
      if (tbl_rd) begin
         tbl_q_ff <= table_mem[idx[WIDX_W-1:0]];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_char = char_ff;
   assign rsp_run_last = last_ff;

endmodule

### hdl/dictionary_word_expander_unit.sv
// Dictionary word expander. A dictionary byte, a phase marker and any byte that gives a single
// result (stream end, name end, bad index, overflow) are taken in the idle state, and such
// words can follow each other every cycle while the result side keeps up. An index byte that
// expands a word of L characters goes through the registered word start table lookup and the
// first dictionary read, then gives one character per cycle while the result side keeps up,
// from the single dictionary read port. The dictionary and the start table are not cleared at
// reset and need no clearing pass; a zero byte resets fill, word count and phase.
module dictionary_word_expander_unit
   import dwe_pkg::*;
#(
   parameter int DICT_BYTES = DICT_BYTES_DEF,
   parameter int DICT_WORDS = DICT_WORDS_DEF,
   parameter int WORD_MAX   = WORD_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_code_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_out_kind,
   output logic [6:0] rsp_out_char,
   output logic       rsp_run_last
);

   cmd_type    cmd;
   status_type status;

   dwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   dwe_datapath #(
      .DICT_BYTES (DICT_BYTES),
      .DICT_WORDS (DICT_WORDS),
      .WORD_MAX   (WORD_MAX)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_code_byte (req_code_byte),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_char  (rsp_out_char),
      .rsp_run_last  (rsp_run_last),
      .cmd           (cmd),
      .status        (status)
   );

   assign req_ready = cmd.take_byte;

   a_accept_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("word accepted while the result register is blocked");

   a_stream_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_code_byte == CODE_STREAM_END |=>
         rsp_valid && rsp_out_kind == KIND_STREAM_END && rsp_run_last)
      else $error("stream end word did not give a stream end result");

   a_non_char_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_CHAR |-> rsp_run_last && rsp_out_char == 7'd0)
      else $error("non-character result is not a final, empty result");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last && rsp_ready |-> !req_ready)
      else $error("new word accepted in the middle of an expansion");

endmodule
